[design/opsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package opsd_pkg;

    localparam int unsigned HeaderLen   = 27;
    localparam int unsigned TypeOffset  = 5;
    localparam int unsigned CountOffset = 26;

    localparam logic [7:0] START_MASK = 8'h02;
    localparam logic [7:0] END_MASK   = 8'h04;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_TABLE  = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_DROP   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_NOT_START = 3'd3;
    localparam logic [2:0] ST_MID_START = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  page_flags;
        logic [15:0] page_length;
        logic [31:0] stream_length;
    } t_out_word;

endpackage

`default_nettype wire

[design/ogg_page_stream_deframer.sv]
// channel  | direction | handshake        | word
// ---------+-----------+------------------+-------------------------------------------
// input    | in        | i_valid/o_stall  | data_byte, end_of_data
// result   | out       | o_valid/i_stall  | status, page_flags, page_length, stream_length
//
// one byte per cycle while o_stall is low; page walk counters update in the accept cycle
// the result of a byte that ends or breaks a page is registered, via skid if o_data is held
// reset (synchronous, active low) starts a new stream and empties the result side
// o_stall comes straight from a skid register, set only when both result slots are full
// bytes that give no result keep flowing while a result waits to be taken
`timescale 1ns / 1ps
`default_nettype none

module ogg_page_stream_deframer
    import opsd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_data
);

    logic [1:0]  r_phase,      n_phase;
    logic [4:0]  r_hdr_cnt,    n_hdr_cnt;
    logic [7:0]  r_flags,      n_flags;
    logic [7:0]  r_seg_total,  n_seg_total;
    logic [7:0]  r_seg_seen,   n_seg_seen;
    logic [15:0] r_body_rem,   n_body_rem;
    logic [15:0] r_page_bytes, n_page_bytes;
    logic [31:0] r_strm_bytes, n_strm_bytes;
    logic        r_first,      n_first;

    logic        r_out_valid;
    t_out_word   r_out;
    logic        r_skid_valid;
    t_out_word   r_skid;

    logic        accept;
    logic        out_take;
    logic        res_valid;
    t_out_word   res;

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        logic       page_done;
        logic       eod;
        logic [7:0] b;
        logic [2:0] st;
        logic       fresh;
        logic       to_drop;

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_flags      = r_flags;
        n_seg_total  = r_seg_total;
        n_seg_seen   = r_seg_seen;
        n_body_rem   = r_body_rem;
        n_page_bytes = r_page_bytes;
        n_strm_bytes = r_strm_bytes;
        n_first      = r_first;
        res_valid    = 1'b0;
        res          = '0;
        page_done    = 1'b0;
        st           = ST_OK;
        fresh        = 1'b0;
        to_drop      = 1'b0;
        eod          = i_data.end_of_data;
        b            = i_data.data_byte;

        if (r_phase == PH_DROP) begin
            fresh = eod;
        end else begin
            if (r_strm_bytes != 32'hFFFF_FFFF) begin
                n_strm_bytes = r_strm_bytes + 32'd1;
            end
            n_page_bytes = r_page_bytes + 16'd1;

            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt == 5'(TypeOffset)) begin
                        n_flags = b;
                    end
                    if (r_hdr_cnt >= 5'(CountOffset)) begin
                        n_seg_total = b;
                        n_seg_seen  = '0;
                        n_body_rem  = '0;
                        n_hdr_cnt   = '0;
                        if (b == 8'd0) begin
                            page_done = 1'b1;
                        end else begin
                            n_phase = PH_TABLE;
                        end
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 5'd1;
                    end
                end
                PH_TABLE: begin
                    n_body_rem = r_body_rem + {8'd0, b};
                    n_seg_seen = r_seg_seen + 8'd1;
                    if (n_seg_seen >= r_seg_total) begin
                        if (n_body_rem == 16'd0) begin
                            page_done = 1'b1;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                default: begin
                    if (r_body_rem != 16'd0) begin
                        n_body_rem = r_body_rem - 16'd1;
                    end
                    if (n_body_rem == 16'd0) begin
                        page_done = 1'b1;
                    end
                end
            endcase

            if (!page_done) begin
                if (eod) begin
                    res_valid = 1'b1;
                    st        = ST_TRUNC;
                    fresh     = 1'b1;
                end
            end else begin
                res_valid = 1'b1;
                if (r_first) begin
                    st = ((n_flags & START_MASK) == 8'd0) ? ST_NOT_START : ST_OK;
                end else if ((n_flags & START_MASK) != 8'd0) begin
                    st = ST_MID_START;
                end else if ((n_flags & END_MASK) != 8'd0) begin
                    st = ST_COMPLETE;
                end else begin
                    st = ST_OK;
                end
                if (st == ST_OK && eod) begin
                    st = ST_TRUNC;
                end
                if (st == ST_OK) begin
                    n_first = 1'b0;
                end else if (st == ST_NOT_START || st == ST_MID_START) begin
                    fresh   = eod;
                    to_drop = !eod;
                end else begin
                    fresh = 1'b1;
                end
            end

            res.status        = st;
            res.page_flags    = n_flags;
            res.page_length   = n_page_bytes;
            res.stream_length = n_strm_bytes;

            if (page_done && !fresh) begin
                n_phase      = to_drop ? PH_DROP : PH_HEADER;
                n_hdr_cnt    = '0;
                n_flags      = '0;
                n_seg_total  = '0;
                n_seg_seen   = '0;
                n_body_rem   = '0;
                n_page_bytes = '0;
            end
        end

        if (fresh) begin
            n_phase      = PH_HEADER;
            n_hdr_cnt    = '0;
            n_flags      = '0;
            n_seg_total  = '0;
            n_seg_seen   = '0;
            n_body_rem   = '0;
            n_page_bytes = '0;
            n_strm_bytes = '0;
            n_first      = 1'b1;
        end
    end

    // page walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= '0;
            r_flags      <= '0;
            r_seg_total  <= '0;
            r_seg_seen   <= '0;
            r_body_rem   <= '0;
            r_page_bytes <= '0;
            r_strm_bytes <= '0;
            r_first      <= 1'b1;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_flags      <= n_flags;
            r_seg_total  <= n_seg_total;
            r_seg_seen   <= n_seg_seen;
            r_body_rem   <= n_body_rem;
            r_page_bytes <= n_page_bytes;
            r_strm_bytes <= n_strm_bytes;
            r_first      <= n_first;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept && res_valid) begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_table_has_segments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TABLE |-> r_seg_total != 8'd0)
        else $error("segment table phase with zero segment count");

    a_body_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_body_rem != 16'd0)
        else $error("body phase with nothing left to take");

    a_drop_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DROP |-> (r_page_bytes == 16'd0 && r_hdr_cnt == 5'd0))
        else $error("drop phase with page counters not cleared");

    a_header_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= 5'(CountOffset))
        else $error("header counter ran past the segment count offset");

    a_header_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TABLE |-> r_page_bytes >= 16'(HeaderLen))
        else $error("segment table reached before a full header");
`endif

endmodule

`default_nettype wire

[tb/sv/opsd_page_monitor.sv]
`timescale 1ns / 1ps

module opsd_page_monitor
    import opsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_reports_due
);

    logic [1:0]  walk_phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  type_byte;
    logic [7:0]  seg_count;
    logic [7:0]  seg_idx;
    logic [15:0] body_left;
    logic [16:0] page_cnt;
    logic [31:0] stream_cnt;
    logic        awaiting_first;
    t_out_word   page_reports_due[$];
    int          fails = 0;

    task automatic clear_page();
        walk_phase = PH_HEADER;
        hdr_idx    = '0;
        type_byte  = '0;
        seg_count  = '0;
        seg_idx    = '0;
        body_left  = '0;
        page_cnt   = '0;
    endtask

    task automatic restart_stream();
        clear_page();
        stream_cnt     = '0;
        awaiting_first = 1'b1;
    endtask

    task automatic post_report(input logic [2:0] st);
        t_out_word rep;
        rep.status        = st;
        rep.page_flags    = type_byte;
        rep.page_length   = page_cnt[15:0];
        rep.stream_length = stream_cnt;
        page_reports_due.push_back(rep);
    endtask

    task automatic deframe_byte(input t_in_word w);
        logic       page_end;
        logic [2:0] st;
        page_end = 1'b0;
        if (walk_phase == PH_DROP) begin
            if (w.end_of_data) restart_stream();
            return;
        end
        if (stream_cnt != '1) stream_cnt++;
        if (page_cnt != '1) page_cnt++;
        case (walk_phase)
            PH_HEADER: begin
                if (hdr_idx == TypeOffset) type_byte = w.data_byte;
                if (hdr_idx >= CountOffset) begin
                    seg_count = w.data_byte;
                    seg_idx   = '0;
                    body_left = '0;
                    hdr_idx   = '0;
                    if (w.data_byte == 8'd0) page_end = 1'b1;
                    else walk_phase = PH_TABLE;
                end else begin
                    hdr_idx++;
                end
            end
            PH_TABLE: begin
                body_left = body_left + 16'(w.data_byte);
                seg_idx++;
                if (seg_idx >= seg_count) begin
                    if (body_left == 16'd0) page_end = 1'b1;
                    else walk_phase = PH_BODY;
                end
            end
            default: begin
                if (body_left != 16'd0) body_left--;
                if (body_left == 16'd0) page_end = 1'b1;
            end
        endcase

        if (!page_end) begin
            if (w.end_of_data) begin
                post_report(ST_TRUNC);
                restart_stream();
            end
            return;
        end

        if (awaiting_first) begin
            st = ((type_byte & START_MASK) != 0) ? ST_OK : ST_NOT_START;
        end else if ((type_byte & START_MASK) != 0) begin
            st = ST_MID_START;
        end else if ((type_byte & END_MASK) != 0) begin
            st = ST_COMPLETE;
        end else begin
            st = ST_OK;
        end
        if (st == ST_OK && w.end_of_data) st = ST_TRUNC;
        post_report(st);

        if (st == ST_OK) begin
            awaiting_first = 1'b0;
            clear_page();
        end else if (st == ST_NOT_START || st == ST_MID_START) begin
            if (w.end_of_data) begin
                restart_stream();
            end else begin
                clear_page();
                walk_phase = PH_DROP;
            end
        end else begin
            restart_stream();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            restart_stream();
            page_reports_due.delete();
        end else begin
            // results always stem from older words, so compare before predicting
            if (i_out_valid && !i_out_stall) begin
                if (page_reports_due.size() == 0) begin
                    $error("page report with none due: %p", i_out_word);
                    fails++;
                end else begin
                    want = page_reports_due.pop_front();
                    if (i_out_word.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_word.status);
                        fails++;
                    end
                    if (i_out_word.page_flags !== want.page_flags) begin
                        $error("page_flags: expected %0h, got %0h",
                               want.page_flags, i_out_word.page_flags);
                        fails++;
                    end
                    if (i_out_word.page_length !== want.page_length) begin
                        $error("page_length: expected %0d, got %0d",
                               want.page_length, i_out_word.page_length);
                        fails++;
                    end
                    if (i_out_word.stream_length !== want.stream_length) begin
                        $error("stream_length: expected %0d, got %0d",
                               want.stream_length, i_out_word.stream_length);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) deframe_byte(i_in_word);
        end
        o_fail_count  <= fails;
        o_reports_due <= page_reports_due.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import opsd_pkg::*;

    localparam int unsigned WORD_TARGET = 1300;
    localparam int unsigned IDLE_LIMIT  = 4000;

    typedef enum logic [1:0] {PG_START, PG_MIDDLE, PG_END} t_page_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    t_in_word    i_data;
    logic        i_stall;
    logic        o_stall;
    logic        o_valid;
    t_out_word   o_data;
    int          fail_count;
    int          reports_due;
    int unsigned words_sent = 0;
    int unsigned idle_cycles = 0;
    bit          calm_sender = 1'b0;
    bit          calm_receiver = 1'b0;
    t_in_word    stream_words[$];

    ogg_page_stream_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    opsd_page_monitor u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_word      (i_data),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_out_word     (o_data),
        .o_fail_count   (fail_count),
        .o_reports_due  (reports_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        t_in_word w;
        w.data_byte   = b;
        w.end_of_data = 1'b0;
        stream_words.push_back(w);
    endtask

    task automatic append_page(input t_page_kind kind);
        logic [7:0]  type_val;
        logic [7:0]  nseg;
        logic [7:0]  len;
        int unsigned r;
        int unsigned body_total;
        bit          zero_body;
        type_val = 8'($urandom);
        case (kind)
            PG_START:  type_val = type_val | START_MASK;
            PG_MIDDLE: type_val = type_val & ~(START_MASK | END_MASK);
            default:   type_val = (type_val & ~START_MASK) | END_MASK;
        endcase
        r = $urandom_range(0, 99);
        if (r < 12) nseg = 8'd0;
        else if (r < 85) nseg = 8'($urandom_range(1, 4));
        else if (r < 97) nseg = 8'($urandom_range(5, 16));
        else nseg = 8'd255;
        zero_body  = ($urandom_range(0, 9) == 0);
        body_total = 0;
        for (int i = 0; i < HeaderLen; i++) begin
            if (i == TypeOffset) put_byte(type_val);
            else if (i == CountOffset) put_byte(nseg);
            else put_byte(8'($urandom));
        end
        for (int i = 0; i < nseg; i++) begin
            r = $urandom_range(0, 99);
            if (zero_body || r < 20) len = 8'd0;
            else if (nseg > 16) len = 8'($urandom_range(0, 2));
            else if (r < 97 || nseg > 4) len = 8'($urandom_range(1, 12));
            else len = 8'($urandom_range(200, 255));
            put_byte(len);
            body_total += 32'(len);
        end
        repeat (body_total) put_byte(8'($urandom));
    endtask

    task automatic build_stream();
        int unsigned r;
        int unsigned first_end;
        int unsigned cut;
        stream_words.delete();
        calm_sender = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 40)) put_byte(8'($urandom));
        end else begin
            if (r < 18) append_page($urandom_range(0, 1) ? PG_MIDDLE : PG_END);
            else append_page(PG_START);
            first_end = stream_words.size() - 1;
            repeat ($urandom_range(0, 3)) append_page(PG_MIDDLE);
            if (r >= 18 && r < 28) append_page(PG_START);
            append_page(PG_END);
            if ((r >= 28 && r < 45) || (r < 28 && $urandom_range(0, 3) == 0)) begin
                if ($urandom_range(0, 2) == 0) cut = first_end;
                else cut = $urandom_range(0, stream_words.size() - 1);
                while (stream_words.size() > cut + 1) void'(stream_words.pop_back());
            end
        end
        // broken streams need the end mark to leave the drop state
        if (r < 45 || $urandom_range(0, 2) == 0)
            stream_words[stream_words.size() - 1].end_of_data = 1'b1;
    endtask

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = pick_gap(calm_sender);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_words[k]) send_word(stream_words[k]);
    endtask

    initial begin
        int unsigned hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) calm_receiver = ~calm_receiver;
            hold = pick_gap(calm_receiver);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("ogg_page_stream_deframer test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short buffers cut inside the header
        stream_words.delete();
        put_byte(8'hFF);
        stream_words[0].end_of_data = 1'b1;
        send_stream();
        stream_words.delete();
        put_byte(8'h00);
        stream_words[0].end_of_data = 1'b1;
        send_stream();
        stream_words.delete();
        for (int i = 0; i <= TypeOffset + 1; i++) put_byte(i == TypeOffset ? 8'hFF : 8'h00);
        stream_words[stream_words.size() - 1].end_of_data = 1'b1;
        send_stream();

        while (words_sent < WORD_TARGET) begin
            build_stream();
            send_stream();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && reports_due == 0) begin
            $display("ogg_page_stream_deframer test passed");
        end else begin
            $display("ogg_page_stream_deframer test failed");
        end
        $finish;
    end

endmodule
